>>> design/stl_pkg.sv
package stl_pkg;

    localparam int COUNT_BITS_DEF    = 16;
    localparam int KEYWORD_CHARS_DEF = 7;

    typedef enum logic [8:0] {
        M_IDLE    = 9'b000000001,
        M_IDENT   = 9'b000000010,
        M_NUMBER  = 9'b000000100,
        M_STRING  = 9'b000001000,
        M_LT      = 9'b000010000,
        M_GT      = 9'b000100000,
        M_BANG    = 9'b001000000,
        M_DASH    = 9'b010000000,
        M_COMMENT = 9'b100000000
    } mode_t;

    localparam logic [5:0] K_IDENT  = 6'd0;
    localparam logic [5:0] K_NUMBER = 6'd1;
    localparam logic [5:0] K_STRING = 6'd2;
    localparam logic [5:0] K_LPAR   = 6'd3;
    localparam logic [5:0] K_RPAR   = 6'd4;
    localparam logic [5:0] K_COMMA  = 6'd5;
    localparam logic [5:0] K_SEMI   = 6'd6;
    localparam logic [5:0] K_PLUS   = 6'd7;
    localparam logic [5:0] K_MINUS  = 6'd8;
    localparam logic [5:0] K_STAR   = 6'd9;
    localparam logic [5:0] K_SLASH  = 6'd10;
    localparam logic [5:0] K_EQ     = 6'd11;
    localparam logic [5:0] K_LE     = 6'd12;
    localparam logic [5:0] K_NE     = 6'd13;
    localparam logic [5:0] K_LT     = 6'd14;
    localparam logic [5:0] K_GE     = 6'd15;
    localparam logic [5:0] K_GT     = 6'd16;
    localparam logic [5:0] K_KW0    = 6'd17;
    localparam logic [5:0] K_END    = 6'd34;

    localparam int NUM_KW = 17;
    localparam logic [2:0] KW_LEN [NUM_KW] = '{
        3'd6, 3'd4, 3'd5, 3'd6, 3'd4, 3'd6, 3'd6, 3'd5, 3'd5, 3'd2,
        3'd7, 3'd7, 3'd7, 3'd4, 3'd3, 3'd2, 3'd3
    };

    typedef struct packed {
        logic       valid;
        logic [5:0] kind;
        logic [15:0] offset;
        logic [15:0] length;
        logic [15:0] line;
        logic [15:0] column;
    } tok_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

endpackage

>>> design/stl_kw_match.sv
module stl_kw_match #(
    parameter int KEYWORD_CHARS = stl_pkg::KEYWORD_CHARS_DEF,
    parameter int COUNT_BITS    = stl_pkg::COUNT_BITS_DEF
) (
    input  logic [8*KEYWORD_CHARS-1:0] window,
    input  logic [COUNT_BITS-1:0]      length,
    output logic [5:0]                 kind
);
    // keyword text, first character in the low byte, zero padded
    function automatic logic [55:0] kw(input int i);
        case (i)
            0:  kw = {8'h00, "TCELES"};
            1:  kw = {24'h0, "MORF"};
            2:  kw = {16'h0, "EREHW"};
            3:  kw = {8'h00, "TRESNI"};
            4:  kw = {24'h0, "OTNI"};
            5:  kw = {8'h00, "SEULAV"};
            6:  kw = {8'h00, "ETAERC"};
            7:  kw = {16'h0, "ELBAT"};
            8:  kw = {16'h0, "XEDNI"};
            9:  kw = {40'h0, "NO"};
            10: kw = "REGETNI";
            11: kw = "RAHCRAV";
            12: kw = "NAELOOB";
            13: kw = {24'h0, "LLUN"};
            14: kw = {32'h0, "DNA"};
            15: kw = {40'h0, "RO"};
            default: kw = {32'h0, "TON"};
        endcase
    endfunction

    logic [8*KEYWORD_CHARS-1:0] ref_w [stl_pkg::NUM_KW];
    logic [stl_pkg::NUM_KW-1:0] hit;

    always_comb
    begin
        for (int i = 0; i < stl_pkg::NUM_KW; i++)
        begin
            ref_w[i] = (8*KEYWORD_CHARS)'(kw(i));
            hit[i] = (length == COUNT_BITS'(stl_pkg::KW_LEN[i])) && (window == ref_w[i]);
        end
        kind = stl_pkg::K_IDENT;
        for (int i = stl_pkg::NUM_KW - 1; i >= 0; i--)
            if (hit[i])
                kind = stl_pkg::K_KW0 + 6'(i);
    end
endmodule

>>> design/sql_token_lexer_unit.sv
// SQL token lexer.
// The first result of a beat is registered and appears in the cycle after the beat is taken.
// Throughput: one input beat per cycle while out_ready is high; a beat with two
// tokens holds the input until the first is taken and the second moves up.
// Reset: rst_n asynchronous, clears scan state to idle, line/column to 1.
module sql_token_lexer_unit #(
    parameter int COUNT_BITS    = stl_pkg::COUNT_BITS_DEF,
    parameter int KEYWORD_CHARS = stl_pkg::KEYWORD_CHARS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [7:0]  char_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  token_kind,
    output logic [15:0] text_offset,
    output logic [15:0] text_length,
    output logic [15:0] line_number,
    output logic [15:0] start_column,
    output logic        last_of_run
);
    localparam int CB = COUNT_BITS;
    localparam logic [CB-1:0] CMAX = '1;
    localparam logic [CB-1:0] ONE  = CB'(1);
    localparam int KW = 8*KEYWORD_CHARS;

    stl_pkg::mode_t mode_reg, mode_next;
    logic quote_dq_reg, quote_dq_next;
    logic [CB-1:0] pos_reg, pos_next, line_reg, line_next, col_reg, col_next;
    logic [CB-1:0] tcol_reg, tcol_next, toff_reg, toff_next, tlen_reg, tlen_next;
    logic [KW-1:0] win_reg, win_next;

    // output stage: two slots, second only used when a beat yields two tokens
    stl_pkg::tok_t slot0_reg, slot1_reg;
    logic last0_reg, last1_reg;
    stl_pkg::tok_t t0, t1;
    logic [5:0] id_kind;

    stl_kw_match #(.KEYWORD_CHARS(KEYWORD_CHARS), .COUNT_BITS(CB)) u_kw (
        .window(win_reg), .length(tlen_reg), .kind(id_kind)
    );

    function automatic logic [CB-1:0] inc(input logic [CB-1:0] v);
        return (v == CMAX) ? v : v + ONE;
    endfunction

    function automatic stl_pkg::tok_t mk(input logic [5:0] k, input logic [CB-1:0] o,
        input logic [CB-1:0] l, input logic [CB-1:0] ln, input logic [CB-1:0] c);
        stl_pkg::tok_t t;
        t.valid = 1'b1; t.kind = k;
        t.offset = 16'(o); t.length = 16'(l); t.line = 16'(ln); t.column = 16'(c);
        return t;
    endfunction

    // output stage empty or draining this cycle
    assign in_ready = !slot1_reg.valid && (!slot0_reg.valid || out_ready);
    wire take = in_valid && in_ready;

    always_comb
    begin
        logic done, flushed;
        logic [7:0] c;
        logic [5:0] pk;
        stl_pkg::tok_t ft, st;
        c = char_byte;
        mode_next = mode_reg; quote_dq_next = quote_dq_reg;
        pos_next = pos_reg; line_next = line_reg; col_next = col_reg;
        tcol_next = tcol_reg; toff_next = toff_reg; tlen_next = tlen_reg;
        win_next = win_reg;
        done = 1'b0; flushed = 1'b0; pk = stl_pkg::K_IDENT;
        ft = '0; st = '0;
        // pending token of current mode
        unique case (mode_reg)
            stl_pkg::M_IDENT:  ft = mk(id_kind, toff_reg, tlen_reg, line_reg, tcol_reg);
            stl_pkg::M_NUMBER: ft = mk(stl_pkg::K_NUMBER, toff_reg, tlen_reg, line_reg, tcol_reg);
            stl_pkg::M_LT:     ft = mk(stl_pkg::K_LT, toff_reg, ONE, line_reg, tcol_reg);
            stl_pkg::M_GT:     ft = mk(stl_pkg::K_GT, toff_reg, ONE, line_reg, tcol_reg);
            stl_pkg::M_DASH:   ft = mk(stl_pkg::K_MINUS, toff_reg, ONE, line_reg, tcol_reg);
            default:           ft = '0;
        endcase
        t0 = '0; t1 = '0;
        if (func)
        begin
            if (ft.valid)
            begin
                t0 = ft;
                t1 = mk(stl_pkg::K_END, pos_reg, '0, line_reg, col_reg);
            end
            else
                t0 = mk(stl_pkg::K_END, pos_reg, '0, line_reg, col_reg);
            mode_next = stl_pkg::M_IDLE; quote_dq_next = 1'b0;
            pos_next = '0; line_next = ONE; col_next = ONE; tcol_next = ONE;
            toff_next = '0; tlen_next = '0; win_next = '0;
        end
        else
        begin
            unique case (mode_reg)
                stl_pkg::M_IDENT:
                    if (stl_pkg::is_alpha(c) || stl_pkg::is_digit(c) || c == "_")
                    begin
                        for (int i = 0; i < KEYWORD_CHARS; i++)
                            if (tlen_reg == CB'(i))
                                win_next[8*i +: 8] = c;
                        tlen_next = inc(tlen_reg); done = 1'b1;
                    end
                    else flushed = 1'b1;
                stl_pkg::M_NUMBER:
                    if (stl_pkg::is_digit(c)) begin tlen_next = inc(tlen_reg); done = 1'b1; end
                    else flushed = 1'b1;
                stl_pkg::M_STRING:
                begin
                    if (c == (quote_dq_reg ? 8'h22 : 8'h27))
                    begin
                        st = mk(stl_pkg::K_STRING, toff_reg, tlen_reg, line_reg, tcol_reg);
                        mode_next = stl_pkg::M_IDLE;
                    end
                    else tlen_next = inc(tlen_reg);
                    done = 1'b1;
                end
                stl_pkg::M_LT:
                    if (c == "=" || c == ">")
                    begin
                        st = mk((c == "=") ? stl_pkg::K_LE : stl_pkg::K_NE, toff_reg,
                                CB'(2), line_reg, tcol_reg);
                        mode_next = stl_pkg::M_IDLE; done = 1'b1;
                    end
                    else flushed = 1'b1;
                stl_pkg::M_GT:
                    if (c == "=")
                    begin
                        st = mk(stl_pkg::K_GE, toff_reg, CB'(2), line_reg, tcol_reg);
                        mode_next = stl_pkg::M_IDLE; done = 1'b1;
                    end
                    else flushed = 1'b1;
                stl_pkg::M_BANG:
                begin
                    if (c == "=")
                    begin
                        st = mk(stl_pkg::K_NE, toff_reg, CB'(2), line_reg, tcol_reg);
                        done = 1'b1;
                    end
                    mode_next = stl_pkg::M_IDLE;
                end
                stl_pkg::M_DASH:
                    if (c == "-") begin mode_next = stl_pkg::M_COMMENT; done = 1'b1; end
                    else flushed = 1'b1;
                stl_pkg::M_COMMENT:
                begin
                    if (c == 8'h0A) mode_next = stl_pkg::M_IDLE;
                    done = 1'b1;
                end
                default: mode_next = stl_pkg::M_IDLE;
            endcase
            if (flushed)
            begin
                st = ft; mode_next = stl_pkg::M_IDLE;
            end
            if (!done)
            begin
                tcol_next = col_reg; toff_next = pos_reg; tlen_next = ONE;
                if (stl_pkg::is_alpha(c) || c == "_")
                begin
                    win_next = KW'(c); mode_next = stl_pkg::M_IDENT;
                end
                else if (stl_pkg::is_digit(c)) mode_next = stl_pkg::M_NUMBER;
                else
                begin
                    case (c)
                        8'h27, 8'h22:
                        begin
                            quote_dq_next = (c == 8'h22);
                            toff_next = inc(pos_reg); tlen_next = '0;
                            mode_next = stl_pkg::M_STRING;
                        end
                        "<": mode_next = stl_pkg::M_LT;
                        ">": mode_next = stl_pkg::M_GT;
                        "!": mode_next = stl_pkg::M_BANG;
                        "-": mode_next = stl_pkg::M_DASH;
                        "(": pk = stl_pkg::K_LPAR;
                        ")": pk = stl_pkg::K_RPAR;
                        ",": pk = stl_pkg::K_COMMA;
                        ";": pk = stl_pkg::K_SEMI;
                        "+": pk = stl_pkg::K_PLUS;
                        "*": pk = stl_pkg::K_STAR;
                        "/": pk = stl_pkg::K_SLASH;
                        "=": pk = stl_pkg::K_EQ;
                        default: pk = stl_pkg::K_IDENT;
                    endcase
                end
            end
            if (pk != stl_pkg::K_IDENT)
            begin
                if (st.valid)
                begin
                    t0 = st; t1 = mk(pk, pos_reg, ONE, line_reg, col_reg);
                end
                else t0 = mk(pk, pos_reg, ONE, line_reg, col_reg);
            end
            else t0 = st;
            pos_next = inc(pos_reg);
            if (c == 8'h0A) begin line_next = inc(line_reg); col_next = ONE; end
            else col_next = inc(col_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= stl_pkg::M_IDLE; quote_dq_reg <= 1'b0;
            pos_reg <= '0; line_reg <= ONE; col_reg <= ONE; tcol_reg <= ONE;
            toff_reg <= '0; tlen_reg <= '0; win_reg <= '0;
            slot0_reg <= '0; slot1_reg <= '0; last0_reg <= 1'b0; last1_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                mode_reg <= mode_next; quote_dq_reg <= quote_dq_next;
                pos_reg <= pos_next; line_reg <= line_next; col_reg <= col_next;
                tcol_reg <= tcol_next; toff_reg <= toff_next; tlen_reg <= tlen_next;
                win_reg <= win_next;
            end
            // a take implies both slots are free or draining now
            if (take)
            begin
                slot0_reg <= t0; last0_reg <= !t1.valid;
                slot1_reg <= t1; last1_reg <= 1'b1;
            end
            else if (slot0_reg.valid && out_ready)
            begin
                slot0_reg <= slot1_reg; last0_reg <= last1_reg;
                slot1_reg <= '0;
            end
        end
    end

    assign out_valid    = slot0_reg.valid;
    assign token_kind   = slot0_reg.kind;
    assign text_offset  = slot0_reg.offset;
    assign text_length  = slot0_reg.length;
    assign line_number  = slot0_reg.line;
    assign start_column = slot0_reg.column;
    assign last_of_run  = last0_reg;

`ifndef SYNTHESIS
    a_no_take_with_two: assert property (@(posedge clk) disable iff (!rst_n)
        slot1_reg.valid |-> !in_ready) else $error("input taken with second beat pending");
    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        slot1_reg.valid |-> slot0_reg.valid) else $error("second slot without first");
    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (take && func) |=> (pos_reg == '0 && mode_reg == stl_pkg::M_IDLE))
        else $error("end beat did not reset scan state");
`endif
endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

// Scoreboard for the lexer: keeps its own copy of the scan state, works out
// the tokens each accepted source beat should produce, and checks them in order.
class token_scoreboard;
    typedef struct {
        logic [5:0]  kind;
        logic [15:0] offset;
        logic [15:0] length;
        logic [15:0] line;
        logic [15:0] column;
        logic        last;
    } token_t;

    token_t           pending_tokens[$];
    int               errors;
    stl_pkg::mode_t   mode;
    bit               dquote;
    logic [15:0]      pos, line, col, tok_col, tok_off, tok_len;
    logic [7:0]       window[7];
    string            keywords[17];

    function new();
        keywords = '{"SELECT", "FROM", "WHERE", "INSERT", "INTO", "VALUES",
                     "CREATE", "TABLE", "INDEX", "ON", "INTEGER", "VARCHAR",
                     "BOOLEAN", "NULL", "AND", "OR", "NOT"};
        errors = 0;
        clear_scan();
    endfunction

    function void clear_scan();
        mode = stl_pkg::M_IDLE;
        dquote = 0;
        pos = 0;
        line = 1;
        col = 1;
        tok_col = 1;
        tok_off = 0;
        tok_len = 0;
        foreach (window[i]) window[i] = 0;
    endfunction

    function logic [15:0] sat(logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function bit alpha(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function bit digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function void emit(logic [5:0] k, logic [15:0] off, logic [15:0] len,
                       logic [15:0] c);
        token_t t;
        t.kind = k;
        t.offset = off;
        t.length = len;
        t.line = line;
        t.column = c;
        t.last = 0;
        pending_tokens.insert(pending_tokens.size(), t);
    endfunction

    function logic [5:0] word_kind();
        bit hit;
        if (tok_len > 7)
            return stl_pkg::K_IDENT;
        for (int i = 0; i < 17; i++)
        begin
            if (keywords[i].len() == tok_len)
            begin
                hit = 1;
                for (int j = 0; j < keywords[i].len(); j++)
                    if (window[j] != keywords[i][j]) hit = 0;
                if (hit) return stl_pkg::K_KW0 + 6'(i);
            end
        end
        return stl_pkg::K_IDENT;
    endfunction

    // emit whatever token the current mode leaves open
    function void close_token();
        case (mode)
            stl_pkg::M_IDENT:  emit(word_kind(), tok_off, tok_len, tok_col);
            stl_pkg::M_NUMBER: emit(stl_pkg::K_NUMBER, tok_off, tok_len, tok_col);
            stl_pkg::M_LT:     emit(stl_pkg::K_LT, tok_off, 1, tok_col);
            stl_pkg::M_GT:     emit(stl_pkg::K_GT, tok_off, 1, tok_col);
            stl_pkg::M_DASH:   emit(stl_pkg::K_MINUS, tok_off, 1, tok_col);
            default: ;
        endcase
        mode = stl_pkg::M_IDLE;
    endfunction

    function void open_token(logic [7:0] c);
        logic [5:0] k;
        tok_col = col;
        tok_off = pos;
        tok_len = 1;
        if (alpha(c) || c == "_")
        begin
            foreach (window[i]) window[i] = 0;
            window[0] = c;
            mode = stl_pkg::M_IDENT;
            return;
        end
        if (digit(c))
        begin
            mode = stl_pkg::M_NUMBER;
            return;
        end
        case (c)
            "'", "\"":
            begin
                dquote = (c == "\"");
                tok_off = sat(pos);
                tok_len = 0;
                mode = stl_pkg::M_STRING;
                return;
            end
            "<": begin mode = stl_pkg::M_LT;   return; end
            ">": begin mode = stl_pkg::M_GT;   return; end
            "!": begin mode = stl_pkg::M_BANG; return; end
            "-": begin mode = stl_pkg::M_DASH; return; end
            "(": k = stl_pkg::K_LPAR;
            ")": k = stl_pkg::K_RPAR;
            ",": k = stl_pkg::K_COMMA;
            ";": k = stl_pkg::K_SEMI;
            "+": k = stl_pkg::K_PLUS;
            "*": k = stl_pkg::K_STAR;
            "/": k = stl_pkg::K_SLASH;
            "=": k = stl_pkg::K_EQ;
            default: return;
        endcase
        emit(k, tok_off, 1, tok_col);
    endfunction

    // one accepted input beat
    function void note_input(bit is_end, logic [7:0] c);
        int  first;
        bit  used;
        first = pending_tokens.size();
        used = 0;
        if (is_end)
        begin
            close_token();
            emit(stl_pkg::K_END, pos, 0, col);
            pending_tokens[$].last = 1;
            clear_scan();
            return;
        end
        case (mode)
            stl_pkg::M_IDENT:
                if (alpha(c) || digit(c) || c == "_")
                begin
                    if (tok_len < 7) window[tok_len] = c;
                    tok_len = sat(tok_len);
                    used = 1;
                end
                else close_token();
            stl_pkg::M_NUMBER:
                if (digit(c))
                begin
                    tok_len = sat(tok_len);
                    used = 1;
                end
                else close_token();
            stl_pkg::M_STRING:
            begin
                if (c == (dquote ? 8'h22 : 8'h27))
                begin
                    emit(stl_pkg::K_STRING, tok_off, tok_len, tok_col);
                    mode = stl_pkg::M_IDLE;
                end
                else tok_len = sat(tok_len);
                used = 1;
            end
            stl_pkg::M_LT:
                if (c == "=" || c == ">")
                begin
                    emit(c == "=" ? stl_pkg::K_LE : stl_pkg::K_NE, tok_off, 2, tok_col);
                    mode = stl_pkg::M_IDLE;
                    used = 1;
                end
                else close_token();
            stl_pkg::M_GT:
                if (c == "=")
                begin
                    emit(stl_pkg::K_GE, tok_off, 2, tok_col);
                    mode = stl_pkg::M_IDLE;
                    used = 1;
                end
                else close_token();
            stl_pkg::M_BANG:
            begin
                if (c == "=")
                begin
                    emit(stl_pkg::K_NE, tok_off, 2, tok_col);
                    used = 1;
                end
                mode = stl_pkg::M_IDLE;
            end
            stl_pkg::M_DASH:
                if (c == "-")
                begin
                    mode = stl_pkg::M_COMMENT;
                    used = 1;
                end
                else close_token();
            stl_pkg::M_COMMENT:
            begin
                if (c == 8'h0A) mode = stl_pkg::M_IDLE;
                used = 1;
            end
            default: mode = stl_pkg::M_IDLE;
        endcase
        if (!used) open_token(c);
        pos = sat(pos);
        if (c == 8'h0A)
        begin
            line = sat(line);
            col = 1;
        end
        else col = sat(col);
        if (pending_tokens.size() > first) pending_tokens[$].last = 1;
    endfunction

    function void check(logic [5:0] k, logic [15:0] off, logic [15:0] len,
                        logic [15:0] ln, logic [15:0] c, logic last);
        token_t e;
        if (pending_tokens.size() == 0)
        begin
            $display("%0t: unexpected token kind %0d", $time, k);
            errors++;
            return;
        end
        e = pending_tokens.pop_front();
        if (k !== e.kind)
        begin
            $display("%0t: token_kind exp %0d got %0d", $time, e.kind, k);
            errors++;
        end
        if (off !== e.offset)
        begin
            $display("%0t: text_offset exp %0d got %0d", $time, e.offset, off);
            errors++;
        end
        if (len !== e.length)
        begin
            $display("%0t: text_length exp %0d got %0d", $time, e.length, len);
            errors++;
        end
        if (ln !== e.line)
        begin
            $display("%0t: line_number exp %0d got %0d", $time, e.line, ln);
            errors++;
        end
        if (c !== e.column)
        begin
            $display("%0t: start_column exp %0d got %0d", $time, e.column, c);
            errors++;
        end
        if (last !== e.last)
        begin
            $display("%0t: last_of_run exp %0d got %0d", $time, e.last, last);
            errors++;
        end
    endfunction
endclass

module tb_top;
    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        func;
    logic [7:0]  char_byte;
    logic        out_valid;
    logic        out_ready;
    logic [5:0]  token_kind;
    logic [15:0] text_offset;
    logic [15:0] text_length;
    logic [15:0] line_number;
    logic [15:0] start_column;
    logic        last_of_run;

    token_scoreboard lex_sb;

    // source stream: bit 8 set marks an end-of-source beat
    logic [8:0]  source_beats[$];
    bit          quiet;      // no idling on either side in the closing stretch
    bit          hold_sink;  // request one long receiver stall

    sql_token_lexer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .char_byte    (char_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .text_offset  (text_offset),
        .text_length  (text_length),
        .line_number  (line_number),
        .start_column (start_column),
        .last_of_run  (last_of_run)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    // every result beat is checked at the rising edge it is taken
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            lex_sb.check(token_kind, text_offset, text_length, line_number,
                         start_column, last_of_run);
    end

    function automatic void queue_beat(logic [8:0] b);
        source_beats.insert(source_beats.size(), b);
    endfunction

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            queue_beat({1'b0, s[i]});
    endtask

    task automatic add_end();
        queue_beat(9'h100);
    endtask

    function automatic logic [7:0] pick_letter();
        logic [7:0] l;
        case ($urandom_range(0, 3))
            0: l = 8'("a" + $urandom_range(0, 25));
            1: l = "_";
            default: l = 8'("A" + $urandom_range(0, 25));
        endcase
        return l;
    endfunction

    // one random lexical fragment; most are well formed, some are noise
    task automatic add_fragment();
        string kws[17];
        string s;
        int    n;
        kws = '{"SELECT", "FROM", "WHERE", "INSERT", "INTO", "VALUES",
                "CREATE", "TABLE", "INDEX", "ON", "INTEGER", "VARCHAR",
                "BOOLEAN", "NULL", "AND", "OR", "NOT"};
        case ($urandom_range(0, 15))
            0, 1: add_text(kws[$urandom_range(0, 16)]);
            2:
            begin
                // keyword with a tail or a cut, or in lower case
                s = kws[$urandom_range(0, 16)];
                case ($urandom_range(0, 2))
                    0: s = {s, "X"};
                    1: s = s.substr(0, s.len() - 2);
                    default: s = s.tolower();
                endcase
                add_text(s);
            end
            3:
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 9);
                for (int i = 0; i < n; i++)
                    queue_beat({1'b0, (i > 0 && $urandom_range(0, 3) == 0) ?
                                8'("0" + $urandom_range(0, 9)) : pick_letter()});
            end
            4:
            begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    queue_beat({1'b0, 8'("0" + $urandom_range(0, 9))});
            end
            5:
            begin
                s = $urandom_range(0, 1) ? "'" : "\"";
                add_text(s);
                n = $urandom_range(0, 10);
                for (int i = 0; i < n; i++)
                    queue_beat({1'b0, 8'($urandom_range(32, 126))});
                if ($urandom_range(0, 7) != 0) add_text(s);
            end
            6: add_text($urandom_range(0, 1) ? "<=" : "<>");
            7: add_text($urandom_range(0, 1) ? ">=" : "!=");
            8:
            begin
                case ($urandom_range(0, 10))
                    0: add_text("(");  1: add_text(")");  2: add_text(",");
                    3: add_text(";");  4: add_text("+");  5: add_text("*");
                    6: add_text("/");  7: add_text("=");  8: add_text("<");
                    9: add_text(">");  default: add_text("-");
                endcase
            end
            9:
            begin
                add_text("--");
                n = $urandom_range(0, 8);
                for (int i = 0; i < n; i++)
                    queue_beat({1'b0, 8'($urandom_range(0, 255))});
                queue_beat({1'b0, 8'h0A});
            end
            10: add_text("!");
            11: queue_beat({1'b0, 8'($urandom_range(0, 255))});
            default:
            begin
                case ($urandom_range(0, 3))
                    0: queue_beat({1'b0, 8'h20});
                    1: queue_beat({1'b0, 8'h09});
                    2: queue_beat({1'b0, 8'h0D});
                    default: queue_beat({1'b0, 8'h0A});
                endcase
            end
        endcase
    endtask

    // receiver: random stall bursts, stretches without stalls, one long hold
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_sink)
            begin
                out_ready = 1'b0;
                repeat (300) @(negedge clk);
                hold_sink = 0;
                out_ready = 1'b1;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
                out_ready = 1'b1;
            end
            else if (!quiet && $urandom_range(0, 40) == 0)
            begin
                out_ready = 1'b1;
                repeat ($urandom_range(20, 60)) @(negedge clk);
            end
            else out_ready = 1'b1;
        end
    end

    // sender: optional gap, then hold the beat until the handshake
    task automatic send_beat(logic [8:0] beat, bit allow_gap);
        if (allow_gap && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        in_valid = 1'b1;
        func = beat[8];
        char_byte = beat[7:0];
        do
            @(posedge clk);
        while (!in_ready);
        lex_sb.note_input(beat[8], beat[7:0]);
        @(negedge clk);
    endtask

    initial
    begin
        int total;
        int burst_free;
        lex_sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = 1'b0;
        char_byte = 8'h00;
        quiet = 0;
        hold_sink = 0;

        // directed: every punctuation mark, most operators (not >= or a lone <), lone bang, byte extremes
        add_text("(),;+*/=<=<>!=<>=>-!x");
        queue_beat({1'b0, 8'hFF});
        queue_beat({1'b0, 8'h00});
        add_text("'ab");
        add_end();
        add_text("SELECT \"q\" 42");
        add_end();
        add_end();

        while (source_beats.size() < 1940)
        begin
            add_fragment();
            if ($urandom_range(0, 5) == 0)
                queue_beat({1'b0, 8'h20});
            if ($urandom_range(0, 60) == 0)
                add_end();
        end
        add_end();
        total = source_beats.size();

        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        burst_free = 0;
        for (int i = 0; i < total; i++)
        begin
            if (i == 600) hold_sink = 1;
            if (i >= total - 250) quiet = 1;
            if (burst_free == 0 && $urandom_range(0, 50) == 0)
                burst_free = $urandom_range(20, 80);
            send_beat(source_beats[i], !quiet && burst_free == 0);
            if (burst_free > 0) burst_free--;
        end
        in_valid = 1'b0;

        while (lex_sb.pending_tokens.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        if (lex_sb.errors == 0 && lex_sb.pending_tokens.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
